/* sv/swm_pkg.sv */
// Shared types and constants of the sliding window median unit.
`timescale 1ns / 1ps

package swm_pkg;

    // Window depth and sample width
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;

    // Register field widths
    localparam int SIZE_BITS     = 7;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = (SAMPLE_BITS > SIZE_BITS) ? SAMPLE_BITS : SIZE_BITS;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_VALUE = CFG_IDX_BITS'(1);

    // Derived widths
    localparam int AGE_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ADDR_BITS = AGE_BITS;
    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int MED_BITS  = SAMPLE_BITS + 1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS = MED_BITS + 2 * SAMPLE_BITS + SUM_BITS;
    localparam int OUT_BITS   = ((OUT_FIELDS + 7) / 8) * 8;

    // One stored slot: value in sorted order plus its age
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic [AGE_BITS-1:0]    age;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // Active window setup handed to the core
    typedef struct packed {
        logic [CNT_BITS-1:0]    size;
        logic [SAMPLE_BITS-1:0] init;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [SAMPLE_BITS-1:0] max;
        logic [SAMPLE_BITS-1:0] min;
        logic [MED_BITS-1:0]    med2;
    } t_result;

endpackage

/* sv/swm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read; a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

/* sv/swm_core.sv */
// Sorted-store sequencer: refill sweep, evict-and-insert merge pass, result capture.
`timescale 1ns / 1ps

module swm_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swm_pkg::t_cfg                  i_cfg,
    input  logic                           i_refill,
    input  logic                           i_start,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                           o_idle,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output swm_pkg::t_result               o_res
);

    import swm_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } t_state;

    t_state                 r_state;
    logic [CNT_BITS-1:0]    r_j;
    logic [CNT_BITS-1:0]    r_w;
    logic [SAMPLE_BITS-1:0] r_s;
    t_entry                 r_buf;
    logic                   r_buf_v;
    logic                   r_removed;
    logic                   r_injected;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;

    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    t_entry                 wr_data;
    logic [ADDR_BITS-1:0]   rd_addr;
    t_entry                 rd_data;

    logic [CNT_BITS-1:0]    last_idx;
    logic [CNT_BITS-1:0]    lo_idx;
    logic [CNT_BITS-1:0]    hi_idx;
    logic [CNT_BITS-1:0]    j_inc;
    logic                   is_oldest;
    logic                   keep;
    logic                   inject;
    t_entry                 aged;
    t_entry                 s_entry;
    t_entry                 emit_val;
    logic                   emit;
    t_entry                 n_buf;
    logic                   n_buf_v;
    logic                   capture;
    logic [SAMPLE_BITS+CNT_BITS:0] fill_sum;

    // Slot store
    swm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Window positions of interest
    assign last_idx = i_cfg.size - 1'b1;
    assign lo_idx   = last_idx >> 1;
    assign hi_idx   = i_cfg.size >> 1;
    assign j_inc    = r_j + 1'b1;
    assign fill_sum = $signed(i_cfg.init) * $signed({1'b0, i_cfg.size});

    // Merge step: drop the oldest slot, age the rest, slip the sample in before
    // the first kept slot that is greater than it
    always_comb begin
        s_entry.value = r_s;
        s_entry.age   = '0;
        aged.value    = rd_data.value;
        aged.age      = AGE_BITS'(rd_data.age + 1'b1);
        is_oldest     = !r_removed && (rd_data.age == AGE_BITS'(last_idx));
        keep          = !is_oldest;
        inject        = !r_injected && keep && ($signed(rd_data.value) > $signed(r_s));
        emit          = 1'b0;
        emit_val      = aged;
        n_buf         = r_buf;
        n_buf_v       = r_buf_v;
        if (r_buf_v) begin
            emit     = 1'b1;
            emit_val = r_buf;
            n_buf    = aged;
            n_buf_v  = keep;
        end else if (inject) begin
            emit     = 1'b1;
            emit_val = s_entry;
            n_buf    = aged;
            n_buf_v  = 1'b1;
        end else if (keep) begin
            emit     = 1'b1;
            emit_val = aged;
        end
    end

    // Memory port steering
    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = r_w[ADDR_BITS-1:0];
        wr_data       = emit_val;
        rd_addr       = '0;
        capture       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = r_j[ADDR_BITS-1:0];
                wr_data.value = i_cfg.init;
                wr_data.age   = AGE_BITS'(last_idx - r_j);
            end
            ST_SCAN: begin
                wr_en   = emit;
                capture = emit;
                rd_addr = j_inc[ADDR_BITS-1:0];
            end
            // Flush the held slot, or place the sample on top when nothing was greater
            ST_FINISH: begin
                wr_en   = r_buf_v || !r_injected;
                capture = r_buf_v || !r_injected;
                wr_data = r_buf_v ? r_buf : s_entry;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_j     <= '0;
        end else if (i_refill) begin
            r_state <= ST_CLEAR;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_sum <= fill_sum[SUM_BITS-1:0];
                    r_j   <= j_inc;
                    if (r_j == last_idx) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_s        <= i_sample;
                        r_j        <= '0;
                        r_w        <= '0;
                        r_buf_v    <= 1'b0;
                        r_removed  <= 1'b0;
                        r_injected <= 1'b0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_j     <= j_inc;
                    r_w     <= r_w + CNT_BITS'(emit);
                    r_buf   <= n_buf;
                    r_buf_v <= n_buf_v;
                    if (is_oldest) begin
                        r_removed <= 1'b1;
                        r_sum     <= r_sum - SUM_BITS'($signed(rd_data.value))
                                           + SUM_BITS'($signed(r_s));
                    end
                    if (inject) begin
                        r_injected <= 1'b1;
                    end
                    if (r_j == last_idx) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end

        // Snoop written slots for min, max and the middle pair
        if (capture) begin
            if (r_w == '0)      r_min <= wr_data.value;
            if (r_w == last_idx) r_max <= wr_data.value;
            if (r_w == lo_idx)  r_lo  <= wr_data.value;
            if (r_w == hi_idx)  r_hi  <= wr_data.value;
        end
    end

    // Result
    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res.med2  = MED_BITS'($signed(r_lo)) + MED_BITS'($signed(r_hi));
    assign o_res.min   = r_min;
    assign o_res.max   = r_max;
    assign o_res.sum   = r_sum;

endmodule

/* sv/sliding_window_median_unit.sv */
// Top level of the sliding window median unit: registers, stream ports, output stage.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// s (in)    in   i_s_tvalid / o_s_tready   i_s_tdata: sample
// m (out)   out  o_m_tvalid / i_m_tready   o_m_tdata: median_times_two, min, max, sum
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A new sample is taken only after the last one is through, N being the
// active window size: one merge pass reads and rewrites the N slots of the sorted
// store through its single read and single write port, one slot per cycle.
// Reset and every write to a listed register start a sweep that refills all N slots of
// the store; no sample is taken during it, register writes are taken at all times.
// A result waits in the output register while the next sample is already processed.

module sliding_window_median_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input samples
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [swm_pkg::IN_BITS-1:0]      i_s_tdata,   // [15:0] sample
    // Results
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [swm_pkg::OUT_BITS-1:0]     o_m_tdata,   // [16:0] median_times_two,
                                                          // [32:17] window_min,
                                                          // [48:33] window_max,
                                                          // [70:49] window_sum
    // Register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [swm_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    import swm_pkg::*;

    logic [SIZE_BITS-1:0]   r_window_size;
    logic [SAMPLE_BITS-1:0] r_initial_value;
    logic                   r_refill;
    logic                   r_out_valid;
    t_result                r_out;

    t_cfg                   cfg;
    logic                   cfg_fire;
    logic                   in_fire;
    logic                   core_idle;
    logic                   res_valid;
    logic                   res_ready;
    t_result                res;

    // Register writes
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= SIZE_BITS'(15);
            r_initial_value <= '0;
            r_refill        <= 1'b0;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_WINDOW_SIZE: begin
                    r_window_size <= i_cfg_data[SIZE_BITS-1:0];
                    r_refill      <= 1'b1;
                end
                REG_INITIAL_VALUE: begin
                    r_initial_value <= i_cfg_data[SAMPLE_BITS-1:0];
                    r_refill        <= 1'b1;
                end
                default: begin
                    r_refill <= 1'b0;
                end
            endcase
        end else begin
            r_refill <= 1'b0;
        end
    end

    // Clamp the window size to the range from one to the store depth
    always_comb begin
        cfg.init = r_initial_value;
        if (r_window_size == '0) begin
            cfg.size = CNT_BITS'(1);
        end else if (r_window_size > MAX_WINDOW) begin
            cfg.size = CNT_BITS'(MAX_WINDOW);
        end else begin
            cfg.size = CNT_BITS'(r_window_size);
        end
    end

    // Input transfer
    assign o_s_tready = core_idle && !r_refill;
    assign in_fire    = i_s_tvalid && o_s_tready;

    swm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_refill    (r_refill),
        .i_start     (in_fire),
        .i_sample    (i_s_tdata[SAMPLE_BITS-1:0]),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'({r_out.sum, r_out.max, r_out.min, r_out.med2});

    // A sample never yields its result in the cycle after its transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !res_valid)
        else $error("result offered one cycle after a sample transfer");

    // A write to a listed register blocks samples while the store refills
    a_refill_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_fire && (i_cfg_index == REG_WINDOW_SIZE || i_cfg_index == REG_INITIAL_VALUE))
        |=> !o_s_tready)
        else $error("sample accepted right after a register write");

    // The core hands over a result only into a free output register
    a_result_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready) |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over a pending output");

    // The core is never idle and done at once
    a_idle_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(core_idle && res_valid))
        else $error("core idle while a result is pending");

endmodule
